// ----- hdl/spq_pkg.sv -----
// Package for the sorted priority queue: request, response and entry types,
// request and status codes. No dependencies.
`default_nettype none

package spq_pkg;

    // request codes
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_PULL   = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam int COUNT_OUT_W = 5;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  priority_req;
        logic [15:0] patient_tag;
        logic [7:0]  ailment_tag;
        logic [7:0]  severity;
        logic [7:0]  time_criticality;
        logic [7:0]  contagiousness;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic                   entry_valid;
        logic [7:0]             out_priority;
        logic [15:0]            out_patient;
        logic [7:0]             out_ailment;
        logic [7:0]             out_severity;
        logic [7:0]             out_time_crit;
        logic [7:0]             out_contagious;
        logic                   is_empty;
        logic [COUNT_OUT_W-1:0] entry_count;
    } t_rsp;

    // one stored queue entry, 56 bits
    typedef struct packed {
        logic [7:0]  prio;
        logic [15:0] patient;
        logic [7:0]  ailment;
        logic [7:0]  sev;
        logic [7:0]  tcrit;
        logic [7:0]  contag;
    } t_entry;

endpackage

`default_nettype wire

// ----- hdl/spq_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on spq_pkg.
`default_nettype none

interface spq_req_if;
    import spq_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface spq_rsp_if;
    import spq_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hdl/spq_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with
// registered, enabled read data. No dependencies.
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ----- hdl/sorted_priority_queue_top.sv -----
// Sorted priority queue top level: sequencer, circular entry store and
// output register. Depends on spq_pkg, spq_if and spq_ram.
//
//  Channel   Dir  Handshake              Carries
//  i_req     in   valid/ready (sink)     insert or pull request with entry fields
//  o_rsp     out  valid/ready (source)   status, reported entry, empty flag, count
//
// An insert walks the store with one comparator from the tail toward the head,
// one entry per cycle, moving each larger entry back by one slot through the
// single RAM write port.
// A pull, a full insert and a pull on empty read the head once and go straight to the output load.
// A synchronous reset empties the queue; store contents stay unwritten.
// A new request is taken while a response waits; its own response holds until
// the output register is free.
`default_nettype none

module sorted_priority_queue_top #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_req_if.sink    i_req,
    spq_rsp_if.source  o_rsp
);

    import spq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;
    localparam int ENT_W = $bits(t_entry);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ISSUE,
        S_CMP,
        S_PLACE,
        S_FRONT,
        S_LOAD
    } t_state;

    t_state           r_state,     n_state;
    logic [IDX_W-1:0] r_head,      n_head;
    logic [IDX_W-1:0] r_tail,      n_tail;
    logic [IDX_W-1:0] r_rd,        n_rd;
    logic [CNT_W-1:0] r_count,     n_count;
    logic [CNT_W-1:0] r_left,      n_left;
    t_entry           r_new,       n_new;
    logic [1:0]       r_status,    n_status;
    logic             r_has,       n_has;
    logic             r_out_valid, n_out_valid;
    t_rsp             r_rsp,       n_rsp;

    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    t_entry           w_wr_data;
    logic             w_rd_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic [ENT_W-1:0] w_rd_bits;
    t_entry           w_rd_entry;
    t_entry           w_in_entry;
    logic [EXT_W-1:0] w_cnt_ext;

    function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        if (p == IDX_W'(QUEUE_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + 1'b1;
        end
        return q;
    endfunction

    function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
        logic [IDX_W-1:0] q;
        if (p == '0) begin
            q = IDX_W'(QUEUE_DEPTH - 1);
        end else begin
            q = p - 1'b1;
        end
        return q;
    endfunction

    spq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_bits)
    );

    assign w_rd_entry = t_entry'(w_rd_bits);

    assign w_in_entry.prio    = i_req.data.priority_req;
    assign w_in_entry.patient = i_req.data.patient_tag;
    assign w_in_entry.ailment = i_req.data.ailment_tag;
    assign w_in_entry.sev     = i_req.data.severity;
    assign w_in_entry.tcrit   = i_req.data.time_criticality;
    assign w_in_entry.contag  = i_req.data.contagiousness;

    assign w_cnt_ext = EXT_W'(r_count);

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_rd        = r_rd;
        n_count     = r_count;
        n_left      = r_left;
        n_new       = r_new;
        n_status    = r_status;
        n_has       = r_has;
        n_rsp       = r_rsp;
        n_out_valid = r_out_valid & ~o_rsp.ready;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_rd;
        w_wr_data   = r_new;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    // read the head now; full insert and pull report it
                    w_rd_en = 1'b1;
                    n_new   = w_in_entry;
                    if (i_req.data.req_type == REQ_INSERT) begin
                        n_has = 1'b1;
                        if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                            n_status = ST_FULL;
                            n_state  = S_LOAD;
                        end else if (r_count == '0) begin
                            n_status  = ST_OK;
                            w_wr_en   = 1'b1;
                            w_wr_addr = r_tail;
                            w_wr_data = w_in_entry;
                            n_tail    = ptr_inc(r_tail);
                            n_count   = r_count + 1'b1;
                            n_state   = S_FRONT;
                        end else begin
                            n_status = ST_OK;
                            n_rd     = ptr_dec(r_tail);
                            n_left   = r_count;
                            n_state  = S_ISSUE;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_has    = 1'b0;
                        end else begin
                            n_status = ST_OK;
                            n_has    = 1'b1;
                            n_head   = ptr_inc(r_head);
                            n_count  = r_count - 1'b1;
                        end
                        n_state = S_LOAD;
                    end
                end
            end
            S_ISSUE: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_rd;
                n_state   = S_CMP;
            end
            S_CMP: begin
                // prefetch the next entry toward the head
                w_rd_en   = 1'b1;
                w_rd_addr = ptr_dec(r_rd);
                w_wr_en   = 1'b1;
                w_wr_addr = ptr_inc(r_rd);
                if (w_rd_entry.prio > r_new.prio) begin
                    // move the larger entry back one slot
                    w_wr_data = w_rd_entry;
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_PLACE;
                    end else begin
                        n_rd   = ptr_dec(r_rd);
                        n_left = r_left - 1'b1;
                    end
                end else begin
                    w_wr_data = r_new;
                    n_tail    = ptr_inc(r_tail);
                    n_count   = r_count + 1'b1;
                    n_state   = S_FRONT;
                end
            end
            S_PLACE: begin
                w_wr_en   = 1'b1;
                w_wr_addr = r_rd;
                w_wr_data = r_new;
                n_tail    = ptr_inc(r_tail);
                n_count   = r_count + 1'b1;
                n_state   = S_FRONT;
            end
            S_FRONT: begin
                w_rd_en = 1'b1;
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // hold until the output register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid       = 1'b1;
                    n_rsp.status      = r_status;
                    n_rsp.entry_valid = r_has;
                    if (r_has) begin
                        n_rsp.out_priority   = w_rd_entry.prio;
                        n_rsp.out_patient    = w_rd_entry.patient;
                        n_rsp.out_ailment    = w_rd_entry.ailment;
                        n_rsp.out_severity   = w_rd_entry.sev;
                        n_rsp.out_time_crit  = w_rd_entry.tcrit;
                        n_rsp.out_contagious = w_rd_entry.contag;
                    end else begin
                        n_rsp.out_priority   = '0;
                        n_rsp.out_patient    = '0;
                        n_rsp.out_ailment    = '0;
                        n_rsp.out_severity   = '0;
                        n_rsp.out_time_crit  = '0;
                        n_rsp.out_contagious = '0;
                    end
                    n_rsp.is_empty    = (r_count == '0);
                    n_rsp.entry_count = w_cnt_ext[COUNT_OUT_W-1:0];
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_rd     <= n_rd;
        r_left   <= n_left;
        r_new    <= n_new;
        r_status <= n_status;
        r_has    <= n_has;
        r_rsp    <= n_rsp;
    end

    // ---------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("stored count exceeds queue depth");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> (r_left != '0))
        else $error("compare step with no entries left to walk");

    a_pull_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.data.req_type == REQ_PULL && r_count != '0)
        |=> (r_count == CNT_W'($past(r_count) - 1'b1)))
        else $error("pull did not remove one entry");

    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.data.entry_valid) |-> (o_rsp.data.status == ST_EMPTY))
        else $error("response without entry but status is not empty");

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
// Self-checking bench for the sorted priority queue: directed and random transfers
// on the request channel, checked against a shadow queue on the response channel.
// Depends on spq_pkg, spq_if and sorted_priority_queue_top.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 150;

    logic clk;
    logic rst_n;

    spq_req_if req_ch ();
    spq_rsp_if rsp_ch ();

    sorted_priority_queue_top #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // shadow of the stored entries, front first
    t_entry triage_order[$];
    t_rsp   awaited_outcomes[$];

    int send_idle_pct = 14;
    int recv_idle_pct = 83;
    int holds_asked   = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic t_rsp report_entry(input t_rsp base, input t_entry e);
        t_rsp r;
        r = base;
        r.entry_valid    = 1'b1;
        r.out_priority   = e.prio;
        r.out_patient    = e.patient;
        r.out_ailment    = e.ailment;
        r.out_severity   = e.sev;
        r.out_time_crit  = e.tcrit;
        r.out_contagious = e.contag;
        return r;
    endfunction

    // Apply one request to the shadow queue and return the response it must cause.
    function automatic t_rsp queue_step_outcome(input t_req r);
        t_rsp   res;
        t_entry ne;
        t_entry pulled;
        int     pos;
        res = '0;
        if (r.req_type == REQ_INSERT) begin
            ne.prio    = r.priority_req;
            ne.patient = r.patient_tag;
            ne.ailment = r.ailment_tag;
            ne.sev     = r.severity;
            ne.tcrit   = r.time_criticality;
            ne.contag  = r.contagiousness;
            if (triage_order.size() >= QUEUE_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                res.status = ST_OK;
                pos = 0;
                // go behind every entry of equal priority
                while (pos < triage_order.size() && triage_order[pos].prio <= ne.prio)
                    pos++;
                triage_order.insert(pos, ne);
            end
            if (triage_order.size() > 0)
                res = report_entry(res, triage_order[0]);
        end else begin
            if (triage_order.size() == 0) begin
                res.status = ST_EMPTY;
            end else begin
                res.status = ST_OK;
                pulled = triage_order.pop_front();
                res = report_entry(res, pulled);
            end
        end
        res.is_empty    = (triage_order.size() == 0);
        res.entry_count = COUNT_OUT_W'(triage_order.size());
        return res;
    endfunction

    function automatic string describe(input t_rsp r);
        return $sformatf("st=%0d v=%0d pr=%0d pt=%0d ai=%0d sv=%0d tc=%0d co=%0d em=%0d n=%0d",
                         r.status, r.entry_valid, r.out_priority, r.out_patient,
                         r.out_ailment, r.out_severity, r.out_time_crit,
                         r.out_contagious, r.is_empty, r.entry_count);
    endfunction

    task automatic check_outcome(input t_rsp got);
        t_rsp want;
        logic bad;
        if (awaited_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected response transfer: %s", describe(got));
        end else begin
            want = awaited_outcomes.pop_front();
            bad = (got.status !== want.status) || (got.entry_valid !== want.entry_valid)
                || (got.out_priority !== want.out_priority)
                || (got.out_patient !== want.out_patient)
                || (got.out_ailment !== want.out_ailment)
                || (got.out_severity !== want.out_severity)
                || (got.out_time_crit !== want.out_time_crit)
                || (got.out_contagious !== want.out_contagious)
                || (got.is_empty !== want.is_empty)
                || (got.entry_count !== want.entry_count);
            if (bad) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("mismatch: expected %s, actual %s", describe(want), describe(got));
            end
        end
    endtask

    // Response side: check each transfer, then pick ready for the next edge.
    initial begin : response_side
        int hold_left;
        int holds_taken;
        hold_left    = 0;
        holds_taken  = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
                check_outcome(rsp_ch.data);
            // start a long hold each time the sequence asks for one
            if (holds_asked != holds_taken) begin
                holds_taken = holds_asked;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Offer one request; valid stays high into the next call unless it idles.
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge clk); while (!req_ch.ready);
        awaited_outcomes.push_back(queue_step_outcome(r));
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (awaited_outcomes.size() != 0);
    endtask

    function automatic t_req make_insert(input logic [7:0] prio, input logic [15:0] patient,
                                         input logic [7:0] ailment, input logic [7:0] sev,
                                         input logic [7:0] tcrit, input logic [7:0] contag);
        t_req r;
        r.req_type         = REQ_INSERT;
        r.priority_req     = prio;
        r.patient_tag      = patient;
        r.ailment_tag      = ailment;
        r.severity         = sev;
        r.time_criticality = tcrit;
        r.contagiousness   = contag;
        return r;
    endfunction

    function automatic t_req rand_request(input int insert_pct);
        t_req r;
        r = make_insert(8'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                        8'($urandom), 8'($urandom));
        if ($urandom_range(99) >= insert_pct)
            r.req_type = REQ_PULL;
        // bias keys toward ties and the ends of the range
        case ($urandom_range(3))
            0: r.priority_req = 8'($urandom_range(3));
            1: r.priority_req = $urandom_range(1) ? 8'hFF : 8'h00;
            2: r.priority_req = 8'($urandom_range(135, 120));
            default: ;
        endcase
        return r;
    endfunction

    task automatic test_pull_when_empty();
        t_req r;
        r = make_insert(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        r.req_type = REQ_PULL;
        send_request(r);
    endtask

    task automatic test_priority_extremes();
        t_req r;
        send_request(make_insert(8'hFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
        send_request(make_insert(8'h00, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00));
        // equal key: must land behind the first 255 entry
        send_request(make_insert(8'hFF, 16'h5AA5, 8'h3C, 8'hC3, 8'h69, 8'h96));
        r = rand_request(0);
        send_request(r);
        send_request(r);
    endtask

    task automatic test_fill_to_capacity();
        int i;
        for (i = 0; i < QUEUE_DEPTH - 1; i++)
            send_request(make_insert(8'($urandom_range(4)), 16'($urandom), 8'($urandom),
                                     8'($urandom), 8'($urandom), 8'($urandom)));
        // one past capacity: dropped with the full status
        send_request(rand_request(100));
    endtask

    task automatic test_output_backpressure();
        int i;
        wait_drained();
        holds_asked++;
        for (i = 0; i < 12; i++)
            send_request(rand_request(60));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n);
        int i;
        int insert_pct;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        insert_pct = 50;
        for (i = 0; i < n; i++) begin
            // swing between filling and draining so both ends are hit often
            if (i % 40 == 0)
                case ($urandom_range(2))
                    0: insert_pct = 85;
                    1: insert_pct = 15;
                    default: insert_pct = 50;
                endcase
            send_request(rand_request(insert_pct));
        end
        wait_drained();
    endtask

    initial begin : test_sequence
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_pull_when_empty();
        test_priority_extremes();
        test_fill_to_capacity();
        test_output_backpressure();
        test_random_traffic(14, 83, 560);
        test_random_traffic(83, 14, 560);
        test_random_traffic(0, 0, 560);
        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && awaited_outcomes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
